// ===== rtl/masked_global_ssim_core_macros.svh =====
`ifndef MASKED_GLOBAL_SSIM_CORE_MACROS_SVH
`define MASKED_GLOBAL_SSIM_CORE_MACROS_SVH

// same-cycle implication
`define MGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define MGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/mgs_pkg.sv =====
package mgs_pkg;

    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned SCORE_FRAC = 30;
    localparam logic [63:0] C_Q24 = 64'd17;
    localparam logic [63:0] ALL64 = '1;

    typedef struct packed {
        logic [15:0] ref_sample;
        logic [15:0] test_sample;
        logic        last_in_band;
    } t_pixel;

    typedef struct packed {
        logic [31:0] band_score;
        logic [31:0] average_score;
        logic [7:0]  band_index;
        logic        final_band;
        logic        empty_mask;
    } t_result;

    typedef struct packed {
        logic         start;
        logic [127:0] a;
        logic [63:0]  b;
        logic [127:0] init;
    } t_mul_req;

    typedef struct packed {
        logic         start;
        logic [4:0]   frac;
        logic [127:0] num;
        logic [127:0] den;
    } t_div_req;

    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL64 : s[63:0];
    endfunction

    function automatic logic [63:0] qscale(input logic [127:0] p);
        logic [127:0] s;
        s = p >> FRAC_BITS;
        return (|s[127:64]) ? ALL64 : s[63:0];
    endfunction

endpackage

// ===== rtl/masked_global_ssim_core.sv =====
// channel   | direction | handshake                 | payload
// pixel     | in        | i_start, o_busy           | i_pixel (t_pixel)
// result    | out       | o_result_valid (strobe)   | o_result (t_result)
// config    | in        | i_cfg_valid, o_cfg_ready  | i_cfg_data (band_count)
//
// A pixel pair that does not end a band is absorbed into the accumulators; busy stays low.
// A band-ending pair runs up to eight passes of the one-bit-per-cycle divider and nineteen
// passes of the 32x32 multiplier; a band with an empty mask skips them all.
// The result strobe is registered from the S_OUT state; the receiver cannot stall.
// Reset is synchronous, active low, and clears all accumulators; band_count resets to 1.
module masked_global_ssim_core #(
    parameter int unsigned PIXEL_COUNT_LOG = 24,
    parameter int unsigned SAMPLE_BITS     = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  mgs_pkg::t_pixel  i_pixel,
    output logic             o_result_valid,
    output mgs_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data
);

    localparam int unsigned CNT_W = PIXEL_COUNT_LOG + 1;
    localparam int unsigned SUM_W = PIXEL_COUNT_LOG + SAMPLE_BITS;
    localparam int unsigned SQ_W  = PIXEL_COUNT_LOG + 2 * SAMPLE_BITS;
    localparam int unsigned SB    = SAMPLE_BITS;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} t_state;
    typedef enum logic [4:0] {
        ST_M1, ST_M3, ST_NQ1, ST_SS1, ST_NN1, ST_V1, ST_NQ3, ST_SS3, ST_NN3, ST_V3,
        ST_N13, ST_S13, ST_S13B, ST_POS, ST_S3B1, ST_NEG1, ST_S1B3, ST_NEG, ST_DCOV,
        ST_COV, ST_MM13, ST_MSQ1, ST_MSQ3, ST_AB, ST_T, ST_S, ST_AVG
    } t_step;

    t_state r_state, n_state;
    t_step  r_step, n_step;

    logic [CNT_W-1:0] r_n1, n_n1, r_n3, n_n3, r_nb, n_nb;
    logic [SUM_W-1:0] r_s1, n_s1, r_s3, n_s3, r_b1, n_b1, r_b3, n_b3;
    logic [SQ_W-1:0]  r_q1, n_q1, r_q3, n_q3, r_x, n_x;
    logic [7:0]       r_band_counter, n_band_counter, r_band_count, n_band_count;
    logic [31:0]      r_score_total, n_score_total, r_score, n_score;
    logic [63:0]      r_m1, n_m1, r_m3, n_m3, r_v1, n_v1, r_v3, n_v3, r_n13, n_n13;
    logic [63:0]      r_aabs, n_aabs, r_bnum, n_bnum, r_d2, n_d2, r_t, n_t;
    logic [127:0]     r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    logic             r_neg, n_neg, r_empty, n_empty, r_valid, n_valid;
    mgs_pkg::t_result r_result, n_result;

    mgs_pkg::t_mul_req mul_req;
    mgs_pkg::t_div_req div_req;
    logic              mul_done, div_done;
    logic [127:0]      mul_p;
    logic [63:0]       div_q;

    logic [SB-1:0]   rs, ts;
    logic [2*SB-1:0] rr, tt, rt;
    logic [7:0]      ec;
    logic            fin;
    logic [63:0]     d1, mm, cov2;
    logic [32:0]     tot;

    mgs_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_prod (mul_p)
    );

    mgs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_q)
    );

    assign rs   = i_pixel.ref_sample[SB-1:0];
    assign ts   = i_pixel.test_sample[SB-1:0];
    assign rr   = rs * rs;
    assign tt   = ts * ts;
    assign rt   = rs * ts;
    assign ec   = (r_band_count == 8'd0) ? 8'd1 : r_band_count;
    assign fin  = ({1'b0, r_band_counter} + 9'd1) >= {1'b0, ec};
    assign d1   = mgs_pkg::sadd(mgs_pkg::sadd(r_v1, r_v3), mgs_pkg::C_Q24);
    assign mm   = mgs_pkg::qscale(mul_p);
    assign cov2 = mgs_pkg::sadd(div_q, div_q);
    assign tot  = {1'b0, r_score_total} + {1'b0, div_q[31:0]};

    assign o_busy         = r_state != S_IDLE;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_valid;
    assign o_result       = r_result;

    always_comb begin
        n_state = r_state;  n_step = r_step;
        n_n1 = r_n1;  n_n3 = r_n3;  n_nb = r_nb;
        n_s1 = r_s1;  n_s3 = r_s3;  n_b1 = r_b1;  n_b3 = r_b3;
        n_q1 = r_q1;  n_q3 = r_q3;  n_x = r_x;
        n_band_counter = r_band_counter;  n_band_count = r_band_count;
        n_score_total = r_score_total;  n_score = r_score;
        n_m1 = r_m1;  n_m3 = r_m3;  n_v1 = r_v1;  n_v3 = r_v3;  n_n13 = r_n13;
        n_aabs = r_aabs;  n_bnum = r_bnum;  n_d2 = r_d2;  n_t = r_t;
        n_w0 = r_w0;  n_w1 = r_w1;  n_w2 = r_w2;
        n_neg = r_neg;  n_empty = r_empty;
        n_valid = 1'b0;  n_result = r_result;
        mul_req = '0;
        div_req = '0;
        if (i_cfg_valid) begin
            n_band_count = i_cfg_data;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (|rs) begin
                        n_n1 = r_n1 + CNT_W'(1);
                        n_s1 = r_s1 + SUM_W'(rs);
                        n_q1 = r_q1 + SQ_W'(rr);
                    end
                    if (|ts) begin
                        n_n3 = r_n3 + CNT_W'(1);
                        n_s3 = r_s3 + SUM_W'(ts);
                        n_q3 = r_q3 + SQ_W'(tt);
                    end
                    if ((|rs) && (|ts)) begin
                        n_nb = r_nb + CNT_W'(1);
                        n_b1 = r_b1 + SUM_W'(rs);
                        n_b3 = r_b3 + SUM_W'(ts);
                        n_x  = r_x + SQ_W'(rt);
                    end
                    if (i_pixel.last_in_band) begin
                        n_state = S_ISSUE;
                        n_step  = ST_M1;
                    end
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
                unique case (r_step)
                    ST_M1: begin
                        n_empty = (r_n1 == '0) || (r_n3 == '0);
                        if (n_empty) begin
                            n_score = '0;
                            n_state = S_OUT;
                        end else begin
                            div_req = '{1'b1, 5'(mgs_pkg::FRAC_BITS), 128'(r_s1), 128'(r_n1)};
                        end
                    end
                    ST_M3:   div_req = '{1'b1, 5'(mgs_pkg::FRAC_BITS), 128'(r_s3), 128'(r_n3)};
                    ST_NQ1:  mul_req = '{1'b1, 128'(r_n1), 64'(r_q1), '0};
                    ST_SS1:  mul_req = '{1'b1, 128'(r_s1), 64'(r_s1), '0};
                    ST_NN1:  mul_req = '{1'b1, 128'(r_n1), 64'(r_n1), '0};
                    ST_V1: begin
                        if (r_w0 >= r_w1) begin
                            div_req = '{1'b1, 5'(mgs_pkg::FRAC_BITS), r_w0 - r_w1, r_w2};
                        end else begin
                            n_v1    = '0;
                            n_step  = ST_NQ3;
                            n_state = S_ISSUE;
                        end
                    end
                    ST_NQ3:  mul_req = '{1'b1, 128'(r_n3), 64'(r_q3), '0};
                    ST_SS3:  mul_req = '{1'b1, 128'(r_s3), 64'(r_s3), '0};
                    ST_NN3:  mul_req = '{1'b1, 128'(r_n3), 64'(r_n3), '0};
                    ST_V3: begin
                        if (r_w0 >= r_w1) begin
                            div_req = '{1'b1, 5'(mgs_pkg::FRAC_BITS), r_w0 - r_w1, r_w2};
                        end else begin
                            n_v3    = '0;
                            n_step  = ST_N13;
                            n_state = S_ISSUE;
                        end
                    end
                    ST_N13:  mul_req = '{1'b1, 128'(r_n1), 64'(r_n3), '0};
                    ST_S13:  mul_req = '{1'b1, 128'(r_s1), 64'(r_s3), '0};
                    ST_S13B: mul_req = '{1'b1, r_w0, 64'(r_nb), '0};
                    ST_POS:  mul_req = '{1'b1, 128'(r_n13), 64'(r_x), r_w0};
                    ST_S3B1: mul_req = '{1'b1, 128'(r_s3), 64'(r_b1), '0};
                    ST_NEG1: mul_req = '{1'b1, r_w1, 64'(r_n1), '0};
                    ST_S1B3: mul_req = '{1'b1, 128'(r_s1), 64'(r_b3), '0};
                    ST_NEG:  mul_req = '{1'b1, r_w2, 64'(r_n3), r_w1};
                    ST_DCOV: mul_req = '{1'b1, 128'(r_n13), 64'(r_n3), '0};
                    ST_COV: begin
                        n_neg   = r_w0 < r_w1;
                        div_req = '{1'b1, 5'(mgs_pkg::FRAC_BITS),
                                    n_neg ? r_w1 - r_w0 : r_w0 - r_w1, r_w2};
                    end
                    ST_MM13: mul_req = '{1'b1, 128'(r_m1), r_m3, '0};
                    ST_MSQ1: mul_req = '{1'b1, 128'(r_m1), r_m1, '0};
                    ST_MSQ3: mul_req = '{1'b1, 128'(r_m3), r_m3, '0};
                    ST_AB:   mul_req = '{1'b1, 128'(r_aabs), r_bnum, '0};
                    ST_T:    div_req = '{1'b1, 5'd0, r_w0, 128'(r_d2)};
                    ST_S:    div_req = '{1'b1, 5'(mgs_pkg::SCORE_FRAC), 128'(r_t), 128'(d1)};
                    ST_AVG:  div_req = '{1'b1, 5'd0, 128'(r_score), 128'(ec)};
                endcase
            end
            S_WAIT: begin
                if (mul_done || div_done) begin
                    n_step  = (r_step == ST_AVG) ? ST_M1 : t_step'(5'(r_step) + 5'd1);
                    n_state = (r_step == ST_AVG) ? S_OUT : S_ISSUE;
                    case (r_step)
                        ST_M1:   n_m1 = div_q;
                        ST_M3:   n_m3 = div_q;
                        ST_V1:   n_v1 = div_q;
                        ST_V3:   n_v3 = div_q;
                        ST_N13:  n_n13 = mul_p[63:0];
                        ST_NQ1, ST_NQ3, ST_S13, ST_S13B, ST_POS, ST_AB: n_w0 = mul_p;
                        ST_SS1, ST_SS3, ST_S3B1, ST_NEG1, ST_NEG:       n_w1 = mul_p;
                        ST_NN1, ST_NN3, ST_S1B3, ST_DCOV:               n_w2 = mul_p;
                        ST_COV: begin
                            if (!r_neg) begin
                                n_aabs = mgs_pkg::sadd(cov2, mgs_pkg::C_Q24);
                            end else if (cov2 >= mgs_pkg::C_Q24) begin
                                n_aabs = cov2 - mgs_pkg::C_Q24;
                            end else begin
                                n_aabs = mgs_pkg::C_Q24 - cov2;
                            end
                        end
                        ST_MM13: n_bnum = mgs_pkg::sadd(mgs_pkg::sadd(mm, mm), mgs_pkg::C_Q24);
                        ST_MSQ1: n_d2 = mm;
                        ST_MSQ3: n_d2 = mgs_pkg::sadd(mgs_pkg::sadd(r_d2, mm), mgs_pkg::C_Q24);
                        ST_T:    n_t = div_q;
                        ST_S:    n_score = (|div_q[63:32]) ? '1 : div_q[31:0];
                        ST_AVG:  n_score_total = tot[32] ? '1 : tot[31:0];
                        default: ;
                    endcase
                end
            end
            S_OUT: begin
                n_valid                  = 1'b1;
                n_result.band_score      = r_score;
                n_result.average_score   = r_score_total;
                n_result.band_index      = r_band_counter;
                n_result.final_band      = fin;
                n_result.empty_mask      = r_empty;
                n_n1 = '0;  n_n3 = '0;  n_nb = '0;
                n_s1 = '0;  n_s3 = '0;  n_b1 = '0;  n_b3 = '0;
                n_q1 = '0;  n_q3 = '0;  n_x = '0;
                if (fin) begin
                    n_band_counter = '0;
                    n_score_total  = '0;
                end else begin
                    n_band_counter = r_band_counter + 8'd1;
                end
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_M1;
            r_valid <= 1'b0;
            r_n1 <= '0;  r_n3 <= '0;  r_nb <= '0;
            r_s1 <= '0;  r_s3 <= '0;  r_b1 <= '0;  r_b3 <= '0;
            r_q1 <= '0;  r_q3 <= '0;  r_x <= '0;
            r_band_counter <= '0;
            r_score_total  <= '0;
            r_band_count   <= 8'd1;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
            r_n1 <= n_n1;  r_n3 <= n_n3;  r_nb <= n_nb;
            r_s1 <= n_s1;  r_s3 <= n_s3;  r_b1 <= n_b1;  r_b3 <= n_b3;
            r_q1 <= n_q1;  r_q3 <= n_q3;  r_x <= n_x;
            r_band_counter <= n_band_counter;
            r_score_total  <= n_score_total;
            r_band_count   <= n_band_count;
        end
        r_score <= n_score;
        r_m1 <= n_m1;  r_m3 <= n_m3;  r_v1 <= n_v1;  r_v3 <= n_v3;  r_n13 <= n_n13;
        r_aabs <= n_aabs;  r_bnum <= n_bnum;  r_d2 <= n_d2;  r_t <= n_t;
        r_w0 <= n_w0;  r_w1 <= n_w1;  r_w2 <= n_w2;
        r_neg <= n_neg;  r_empty <= n_empty;
        r_result <= n_result;
    end

endmodule

// ===== rtl/mgs_mul.sv =====
module mgs_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mgs_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [127:0]      o_prod
);

    logic [127:0] r_a;
    logic [63:0]  r_b;
    logic [2:0]   r_k;
    logic         r_run;
    logic         r_ppv;
    logic [63:0]  r_pp;
    logic [2:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;
    logic [31:0]  a_part;
    logic [31:0]  b_part;

    assign a_part = r_a[{r_k[2:1], 5'd0} +: 32];
    assign b_part = r_b[{r_k[0], 5'd0} +: 32];
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_ppv && !r_run && !i_req.start;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_ppv <= 1'b0;
                r_k   <= '0;
                r_a   <= i_req.a;
                r_b   <= i_req.b;
                r_acc <= i_req.init;
            end else begin
                r_ppv <= r_run;
                if (r_run) begin
                    r_pp <= a_part * b_part;
                    r_sh <= {1'b0, r_k[2:1]} + {2'b0, r_k[0]};
                    r_k  <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_run <= 1'b0;
                    end
                end
                if (r_ppv) begin
                    r_acc <= r_acc + (128'(r_pp) << {r_sh, 5'd0});
                end
            end
        end
    end

endmodule

// ===== rtl/mgs_div.sv =====
module mgs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mgs_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_quot
);

    logic [127:0] r_num;
    logic [127:0] r_den;
    logic [127:0] r_rem;
    logic [63:0]  r_q;
    logic         r_over;
    logic [7:0]   r_cnt;
    logic         r_done;
    logic [127:0] rem2;
    logic         ge;

    assign rem2   = {r_rem[126:0], r_num[127]};
    assign ge     = rem2 >= r_den;
    assign o_done = r_done;
    assign o_quot = r_over ? mgs_pkg::ALL64 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 8'd1) && !i_req.start;
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_cnt  <= 8'd128 + 8'(i_req.frac);
            end else if (r_cnt != 8'd0) begin
                r_num  <= r_num << 1;
                r_rem  <= ge ? rem2 - r_den : rem2;
                r_q    <= {r_q[62:0], ge};
                r_over <= r_over | r_q[63];
                r_cnt  <= r_cnt - 8'd1;
            end
        end
    end

endmodule

// ===== rtl/mgs_checker.sv =====
`include "masked_global_ssim_core_macros.svh"

module mgs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input mgs_pkg::t_pixel  i_pixel,
    input logic             o_result_valid,
    input mgs_pkg::t_result o_result
);

    `MGS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_result_valid && o_result.empty_mask, o_result.band_score == 32'd0)
    `MGS_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_result_valid, !o_busy && $past(o_busy))
    `MGS_ASSERT_NXT(a_last_busy, i_clk, i_rst_n, i_start && !o_busy && i_pixel.last_in_band, o_busy && !o_result_valid)
    `MGS_ASSERT_NXT(a_pixel_free, i_clk, i_rst_n, i_start && !o_busy && !i_pixel.last_in_band, !o_busy)

endmodule

bind masked_global_ssim_core mgs_checker u_mgs_checker (.*);
